// ===== hdl/fp16_sigmoid_gated_activation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gated sigmoid activation
// Expects clk and rst_n in the scope of the use.
// ----------------------------------------------------------------------------
`ifndef FP16_SIGMOID_GATED_ACTIVATION_ASSERT_SVH
`define FP16_SIGMOID_GATED_ACTIVATION_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define FSGA_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsga check failed");

// consequent must hold in the same cycle as the antecedent
`define FSGA_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsga check failed");

`endif

// ===== hdl/fsga_pkg.sv =====
// ----------------------------------------------------------------------------
// fsga_pkg
// Shared constants, types and fp16 arithmetic functions.
// ----------------------------------------------------------------------------
package fsga_pkg;

    localparam logic [15:0] H_ONE     = 16'h3C00;
    localparam logic [15:0] H_NAN     = 16'h7E00;
    localparam logic [15:0] H_INF     = 16'h7C00;
    localparam logic [15:0] H_NZERO   = 16'h8000;
    localparam logic [15:0] H_SIGN    = 16'h8000;
    localparam logic [15:0] H_CLAMP   = 16'hCC56;
    localparam logic [15:0] H_INV_LN2 = 16'h3DC5;
    localparam logic [15:0] H_LN2_HI  = 16'h398C;
    localparam logic [15:0] H_LN2_LO  = 16'h8AF4;
    localparam logic [15:0] H_P2      = 16'h3809;
    localparam logic [15:0] H_P3      = 16'h315D;
    localparam logic [15:0] H_DOWN11  = 16'h1000;
    localparam logic [7:0]  EXP_STEP0 = 8'd88;

    // configuration register indexes
    localparam logic [1:0] CFG_BETA_SCALE = 2'd0;
    localparam logic [1:0] CFG_UP_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_USE_Y      = 2'd2;
    localparam logic [1:0] CFG_USE_UP     = 2'd3;

    localparam logic [6:0] REC7_TAB [0:127] = '{
        7'd127, 7'd125, 7'd123, 7'd121, 7'd119, 7'd117, 7'd116, 7'd114,
        7'd112, 7'd110, 7'd109, 7'd107, 7'd105, 7'd104, 7'd102, 7'd100,
        7'd99,  7'd97,  7'd96,  7'd94,  7'd93,  7'd91,  7'd90,  7'd88,
        7'd87,  7'd85,  7'd84,  7'd83,  7'd81,  7'd80,  7'd79,  7'd77,
        7'd76,  7'd75,  7'd74,  7'd72,  7'd71,  7'd70,  7'd69,  7'd68,
        7'd66,  7'd65,  7'd64,  7'd63,  7'd62,  7'd61,  7'd60,  7'd59,
        7'd58,  7'd57,  7'd56,  7'd55,  7'd54,  7'd53,  7'd52,  7'd51,
        7'd50,  7'd49,  7'd48,  7'd47,  7'd46,  7'd45,  7'd44,  7'd43,
        7'd42,  7'd41,  7'd40,  7'd40,  7'd39,  7'd38,  7'd37,  7'd36,
        7'd35,  7'd35,  7'd34,  7'd33,  7'd32,  7'd31,  7'd31,  7'd30,
        7'd29,  7'd28,  7'd28,  7'd27,  7'd26,  7'd25,  7'd25,  7'd24,
        7'd23,  7'd23,  7'd22,  7'd21,  7'd21,  7'd20,  7'd19,  7'd19,
        7'd18,  7'd17,  7'd17,  7'd16,  7'd15,  7'd15,  7'd14,  7'd14,
        7'd13,  7'd12,  7'd12,  7'd11,  7'd11,  7'd10,  7'd9,   7'd9,
        7'd8,   7'd8,   7'd7,   7'd7,   7'd6,   7'd5,   7'd5,   7'd4,
        7'd4,   7'd3,   7'd3,   7'd2,   7'd2,   7'd1,   7'd1,   7'd0
    };

    // side-band that travels with each element
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        neg;
        logic [15:0] y;
        logic [15:0] upsum;
    } fsga_side_t;

    function automatic logic fp16_is_nan(input logic [15:0] h);
        fp16_is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    // a*b + c with a single round to nearest even; mul uses c = -0, add uses b = 1
    function automatic logic [15:0] fp16_fma(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] c);
        logic [4:0]  ea, eb, ec;
        logic [10:0] ma, mb, mc;
        logic [21:0] pm;
        logic [5:0]  psh, csh;
        logic [83:0] pv, cv, mag, q, smask;
        logic        ps, cs, sg, guard, sticky, rnd;
        logic [6:0]  k, lsb;
        logic [11:0] mant;
        logic [17:0] enc;
        logic        a_inf, b_inf, c_inf, a_zero, b_zero, p_inf, p_nan;
        logic [15:0] res;
        ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
        eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
        ec = (c[14:10] == 5'd0) ? 5'd1 : c[14:10];
        ma = {a[14:10] != 5'd0, a[9:0]};
        mb = {b[14:10] != 5'd0, b[9:0]};
        mc = {c[14:10] != 5'd0, c[9:0]};
        pm = 22'(ma) * 22'(mb);
        psh = 6'(ea) + 6'(eb) - 6'd2;
        csh = 6'(ec) + 6'd23;
        // fixed point, lsb weight 2^-48
        pv = 84'(pm) << psh;
        cv = 84'(mc) << csh;
        ps = a[15] ^ b[15];
        cs = c[15];
        if (ps == cs)
        begin
            mag = pv + cv;
            sg  = ps;
        end
        else if (pv >= cv)
        begin
            mag = pv - cv;
            sg  = ps;
        end
        else
        begin
            mag = cv - pv;
            sg  = cs;
        end
        if (mag == 84'd0)
            sg = ps & cs;
        k = 7'd0;
        for (int i = 0; i < 84; i++)
        begin
            if (mag[i])
                k = 7'(i);
        end
        // bit 24 carries 2^-24, the subnormal quantum
        lsb    = (k >= 7'd34) ? (k - 7'd10) : 7'd24;
        q      = mag >> lsb;
        guard  = mag[lsb - 7'd1];
        smask  = (84'd1 << (lsb - 7'd1)) - 84'd1;
        sticky = |(mag & smask);
        rnd    = guard & (sticky | q[0]);
        mant   = q[11:0] + 12'(rnd);
        enc    = {1'b0, 7'(lsb - 7'd24), 10'd0} + 18'(mant);
        if (enc >= 18'h07C00)
            res = {sg, H_INF[14:0]};
        else
            res = {sg, enc[14:0]};
        a_inf  = (a[14:10] == 5'h1F) && (a[9:0] == 10'd0);
        b_inf  = (b[14:10] == 5'h1F) && (b[9:0] == 10'd0);
        c_inf  = (c[14:10] == 5'h1F) && (c[9:0] == 10'd0);
        a_zero = (a[14:0] == 15'd0);
        b_zero = (b[14:0] == 15'd0);
        p_inf  = a_inf | b_inf;
        p_nan  = fp16_is_nan(a) | fp16_is_nan(b) | (a_inf & b_zero) | (b_inf & a_zero);
        if (p_nan || fp16_is_nan(c) || (p_inf && c_inf && (ps != cs)))
            res = H_NAN;
        else if (p_inf)
            res = {ps, H_INF[14:0]};
        else if (c_inf)
            res = {cs, H_INF[14:0]};
        fp16_fma = res;
    endfunction

    // fp16 to int8, nearest even, saturating; NaN gives 127
    function automatic logic [7:0] fp16_to_i8(input logic [15:0] h);
        logic [4:0]  e;
        logic [10:0] m, q, smask;
        logic [31:0] mw;
        logic [4:0]  sh;
        logic        guard, sticky, rnd;
        logic [8:0]  mag;
        logic [7:0]  res;
        e = (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
        m = {h[14:10] != 5'd0, h[9:0]};
        mw = 32'(m);
        sh = 5'd25 - ((e > 5'd21) ? 5'd21 : e);
        q = m >> sh;
        // guard may sit above the significand for small values
        guard = mw[sh - 5'd1];
        smask = 11'((32'd1 << (sh - 5'd1)) - 32'd1);
        sticky = |(m & smask);
        rnd = guard & (sticky | q[0]);
        mag = 9'(q) + 9'(rnd);
        if (e > 5'd21)
            mag = 9'd256;
        if (fp16_is_nan(h))
            res = 8'd127;
        else if (h[15])
            res = (mag >= 9'd128) ? 8'h80 : 8'(-mag);
        else
            res = (mag >= 9'd128) ? 8'd127 : mag[7:0];
        fp16_to_i8 = res;
    endfunction

    // int8 to fp16, exact
    function automatic logic [15:0] i8_to_fp16(input logic [7:0] v);
        logic [7:0]  mag;
        logic [2:0]  p;
        logic [17:0] sig;
        logic [15:0] res;
        mag = v[7] ? 8'(-v) : v;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mag[i])
                p = 3'(i);
        end
        sig = 18'(mag) << (5'd10 - 5'(p));
        res = {v[7], 5'(5'd15 + 5'(p)), sig[9:0]};
        if (mag == 8'd0)
            res = 16'd0;
        i8_to_fp16 = res;
    endfunction

    // 7-bit reciprocal estimate
    function automatic logic [15:0] fp16_rec7(input logic [15:0] h);
        logic        sg;
        logic [9:0]  sig, nsig;
        logic [3:0]  p;
        logic        found;
        logic [5:0]  ne, oe;
        logic [9:0]  osig;
        logic [10:0] sub;
        logic [15:0] res;
        sg = h[15];
        sig = h[9:0];
        p = 4'd0;
        found = 1'b0;
        for (int i = 0; i < 10; i++)
        begin
            if (sig[i])
            begin
                p = 4'(i);
                found = 1'b1;
            end
        end
        if (h[14:10] == 5'd0)
        begin
            ne = 6'(p) - 6'd9;
            nsig = 10'(sig << (4'd10 - p));
        end
        else
        begin
            ne = 6'(h[14:10]);
            nsig = sig;
        end
        osig = {REC7_TAB[nsig[9:3]], 3'b000};
        oe = 6'd29 - ne;
        sub = {1'b1, osig} >> (6'd1 - oe);
        if ($signed(oe) >= 6'sd1)
            res = {sg, oe[4:0], osig};
        else
            res = {sg, 4'd0, sub};
        if (h[14:10] == 5'h1F)
            res = (sig != 10'd0) ? H_NAN : {sg, 15'd0};
        else if (h[14:10] == 5'd0 && (!found || p < 4'd8))
            res = {sg, H_INF[14:0]};
        fp16_rec7 = res;
    endfunction

endpackage

// ===== hdl/fp16_sigmoid_gated_activation.sv =====
// ----------------------------------------------------------------------------
// fp16_sigmoid_gated_activation
// Gated sigmoid activation on fp16 elements, one element per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries x, y and up per element plus tlast; the
//   output stream m_axis returns one fp16 result per element with its tlast.
//   Results are sigmoid(beta*x), optionally times y and times (up + offset).
//   The pipeline has 16 register stages, each with at most one fp16 fused
//   multiply-add except the first, which forms both beta*x and up + offset.
//   Throughput is one element per cycle while the receiver does not stall;
//   stages carry valid bits, so bubbles pass through without cost.
//   When the receiver stalls, every stage holds and s_axis_tready drops in the
//   same cycle; nothing is lost or repeated.
//   Reset empties the pipeline and loads beta_scale = 1.0, up_offset = 0,
//   use_y = 0, use_up = 0. Write registers through cfg_we/cfg_index/cfg_wdata
//   only while no element is in flight.
// ----------------------------------------------------------------------------
`include "fp16_sigmoid_gated_activation_assert.svh"

module fp16_sigmoid_gated_activation
    import fsga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // x_value[15:0], y_value[31:16], up_value[47:32]
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result_bits[15:0]
    output logic        m_axis_tlast,   // last_out
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] beta_scale_reg, up_offset_reg;
    logic        use_y_reg, use_up_reg;
    logic        adv;
    logic        stall;
    logic [15:0] red_rem, exp_ex, exp_den;
    logic [7:0]  red_zi;
    fsga_side_t  red_side, exp_side;

    // advance all stages when the output slot is free or being drained
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign stall         = m_axis_tvalid && !m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_scale_reg <= H_ONE;
            up_offset_reg  <= 16'd0;
            use_y_reg      <= 1'b0;
            use_up_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BETA_SCALE: beta_scale_reg <= cfg_wdata;
                CFG_UP_OFFSET:  up_offset_reg  <= cfg_wdata;
                CFG_USE_Y:      use_y_reg      <= cfg_wdata[0];
                CFG_USE_UP:     use_up_reg     <= cfg_wdata[0];
                default:        use_up_reg     <= use_up_reg;
            endcase
        end
    end

    fsga_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_axis_tvalid),
        .x_value    (s_axis_tdata[15:0]),
        .y_value    (s_axis_tdata[31:16]),
        .up_value   (s_axis_tdata[47:32]),
        .last_in    (s_axis_tlast),
        .beta_scale (beta_scale_reg),
        .up_offset  (up_offset_reg),
        .rem        (red_rem),
        .zi         (red_zi),
        .side       (red_side)
    );

    fsga_expo u_expo (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .rem     (red_rem),
        .zi      (red_zi),
        .side_in (red_side),
        .ex      (exp_ex),
        .den     (exp_den),
        .side    (exp_side)
    );

    fsga_gate u_gate (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .ex          (exp_ex),
        .den         (exp_den),
        .side_in     (exp_side),
        .use_y       (use_y_reg),
        .use_up      (use_up_reg),
        .out_valid   (m_axis_tvalid),
        .result_bits (m_axis_tdata),
        .last_out    (m_axis_tlast)
    );

    `FSGA_CHECK_NEXT(a_stall_holds_reduce, stall, $stable(red_side) && $stable(red_rem))
    `FSGA_CHECK_NEXT(a_stall_holds_expo, stall, $stable(exp_side) && $stable(exp_den))
    `FSGA_CHECK_NOW(a_no_intake_on_stall, stall, !s_axis_tready)

endmodule

// ===== hdl/fsga_reduce.sv =====
// ----------------------------------------------------------------------------
// fsga_reduce
// Slope, fold and clamp, split by ln2 into integer step and remainder.
// ----------------------------------------------------------------------------
module fsga_reduce
    import fsga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [15:0] x_value,
    input  logic [15:0] y_value,
    input  logic [15:0] up_value,
    input  logic        last_in,
    input  logic [15:0] beta_scale,
    input  logic [15:0] up_offset,
    output logic [15:0] rem,
    output logic [7:0]  zi,
    output fsga_side_t  side
);

    fsga_side_t  s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next;
    fsga_side_t  s4_reg, s4_next, s5_reg, s5_next;
    logic [15:0] vx1_reg, vx1_next, vx2_reg, vx2_next, v2_reg, v2_next;
    logic [15:0] vx3_reg, vx3_next, z3_reg, z3_next, z4_reg, z4_next;
    logic [15:0] s4v_reg, s4v_next, s5v_reg, s5v_next;
    logic [7:0]  zi3_reg, zi3_next, zi4_reg, zi4_next, zi5_reg, zi5_next;
    logic [14:0] mag1;

    assign mag1 = vx1_reg[14:0];

    always_comb
    begin
        s1_next       = '0;
        s1_next.valid = in_valid;
        s1_next.last  = last_in;
        s1_next.y     = y_value;
        s1_next.upsum = fp16_fma(up_value, H_ONE, up_offset);
        vx1_next      = (beta_scale != H_ONE) ? fp16_fma(x_value, beta_scale, H_NZERO)
                                              : x_value;
        // fold to -|x|; a NaN magnitude also lands on the clamp
        s2_next       = s1_reg;
        s2_next.neg   = vx1_reg[15] && (mag1 != 15'd0) && !fp16_is_nan(vx1_reg);
        vx2_next      = (mag1 > H_CLAMP[14:0]) ? H_CLAMP : {1'b1, mag1};
        v2_next       = fp16_fma((mag1 > H_CLAMP[14:0]) ? H_CLAMP : {1'b1, mag1},
                                 H_INV_LN2, H_NZERO);
        s3_next       = s2_reg;
        zi3_next      = fp16_to_i8(v2_reg);
        z3_next       = i8_to_fp16(fp16_to_i8(v2_reg));
        vx3_next      = vx2_reg;
        s4_next       = s3_reg;
        s4v_next      = fp16_fma(H_LN2_HI ^ H_SIGN, z3_reg, vx3_reg);
        z4_next       = z3_reg;
        zi4_next      = zi3_reg;
        s5_next       = s4_reg;
        s5v_next      = fp16_fma(H_LN2_LO ^ H_SIGN, z4_reg, s4v_reg);
        zi5_next      = zi4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx1_reg <= vx1_next;
            vx2_reg <= vx2_next;
            v2_reg  <= v2_next;
            vx3_reg <= vx3_next;
            z3_reg  <= z3_next;
            zi3_reg <= zi3_next;
            s4v_reg <= s4v_next;
            z4_reg  <= z4_next;
            zi4_reg <= zi4_next;
            s5v_reg <= s5v_next;
            zi5_reg <= zi5_next;
        end
    end

    assign rem  = s5v_reg;
    assign zi   = zi5_reg;
    assign side = s5_reg;

endmodule

// ===== hdl/fsga_expo.sv =====
// ----------------------------------------------------------------------------
// fsga_expo
// Cubic for exp(s), exponent insertion, 2^-11 scaling and the 1+e sum.
// ----------------------------------------------------------------------------
module fsga_expo
    import fsga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [15:0] rem,
    input  logic [7:0]  zi,
    input  fsga_side_t  side_in,
    output logic [15:0] ex,
    output logic [15:0] den,
    output fsga_side_t  side
);

    fsga_side_t  s6_reg, s6_next, s7_reg, s7_next, s8_reg, s8_next;
    fsga_side_t  s9_reg, s9_next, s10_reg, s10_next;
    logic [15:0] r6_reg, r6_next, u6_reg, u6_next, r7_reg, r7_next, u7_reg, u7_next;
    logic [15:0] e8_reg, e8_next, ex9_reg, ex9_next, ex10_reg, ex10_next;
    logic [15:0] d10_reg, d10_next, u8;
    logic [7:0]  zi6_reg, zi6_next, zi7_reg, zi7_next, step8;

    always_comb
    begin
        s6_next   = side_in;
        u6_next   = fp16_fma(H_P3, rem, H_P2);
        r6_next   = rem;
        zi6_next  = zi;
        s7_next   = s6_reg;
        u7_next   = fp16_fma(r6_reg, u6_reg, H_ONE);
        r7_next   = r6_reg;
        zi7_next  = zi6_reg;
        // add the wrapped step (11 + z) * 8 into the exponent field
        s8_next   = s7_reg;
        u8        = fp16_fma(r7_reg, u7_reg, H_ONE);
        step8     = EXP_STEP0 + {zi7_reg[4:0], 3'b000};
        e8_next   = u8 + {step8[7], step8, 7'd0};
        s9_next   = s8_reg;
        ex9_next  = fp16_fma(e8_reg, H_DOWN11, H_NZERO);
        s10_next  = s9_reg;
        d10_next  = fp16_fma(ex9_reg, H_ONE, H_ONE);
        ex10_next = ex9_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_reg  <= '0;
            s7_reg  <= '0;
            s8_reg  <= '0;
            s9_reg  <= '0;
            s10_reg <= '0;
        end
        else if (adv)
        begin
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            s9_reg  <= s9_next;
            s10_reg <= s10_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u6_reg   <= u6_next;
            r6_reg   <= r6_next;
            zi6_reg  <= zi6_next;
            u7_reg   <= u7_next;
            r7_reg   <= r7_next;
            zi7_reg  <= zi7_next;
            e8_reg   <= e8_next;
            ex9_reg  <= ex9_next;
            d10_reg  <= d10_next;
            ex10_reg <= ex10_next;
        end
    end

    assign ex   = ex10_reg;
    assign den  = d10_reg;
    assign side = s10_reg;

endmodule

// ===== hdl/fsga_gate.sv =====
// ----------------------------------------------------------------------------
// fsga_gate
// Reciprocal estimate with one Newton step, sign select and optional gates.
// ----------------------------------------------------------------------------
module fsga_gate
    import fsga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [15:0] ex,
    input  logic [15:0] den,
    input  fsga_side_t  side_in,
    input  logic        use_y,
    input  logic        use_up,
    output logic        out_valid,
    output logic [15:0] result_bits,
    output logic        last_out
);

    fsga_side_t  s11_reg, s11_next, s12_reg, s12_next, s13_reg, s13_next;
    fsga_side_t  s14_reg, s14_next, s15_reg, s15_next;
    logic        v16_reg, v16_next, l16_reg, l16_next;
    logic [15:0] d11_reg, d11_next, r11_reg, r11_next, ex11_reg, ex11_next;
    logic [15:0] t12_reg, t12_next, r12_reg, r12_next, ex12_reg, ex12_next;
    logic [15:0] r13_reg, r13_next, ex13_reg, ex13_next;
    logic [15:0] q14_reg, q14_next, q15_reg, q15_next, q16_reg, q16_next;

    always_comb
    begin
        s11_next  = side_in;
        r11_next  = fp16_rec7(den);
        d11_next  = den;
        ex11_next = ex;
        s12_next  = s11_reg;
        t12_next  = fp16_fma(d11_reg ^ H_SIGN, r11_reg, H_ONE);
        r12_next  = r11_reg;
        ex12_next = ex11_reg;
        s13_next  = s12_reg;
        r13_next  = fp16_fma(t12_reg, r12_reg, r12_reg);
        ex13_next = ex12_reg;
        s14_next  = s13_reg;
        q14_next  = s13_reg.neg ? fp16_fma(r13_reg, ex13_reg, H_NZERO) : r13_reg;
        s15_next  = s14_reg;
        q15_next  = use_y ? fp16_fma(q14_reg, s14_reg.y, H_NZERO) : q14_reg;
        v16_next  = s15_reg.valid;
        l16_next  = s15_reg.last;
        q16_next  = use_up ? fp16_fma(q15_reg, s15_reg.upsum, H_NZERO) : q15_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s11_reg <= '0;
            s12_reg <= '0;
            s13_reg <= '0;
            s14_reg <= '0;
            s15_reg <= '0;
            v16_reg <= 1'b0;
        end
        else if (adv)
        begin
            s11_reg <= s11_next;
            s12_reg <= s12_next;
            s13_reg <= s13_next;
            s14_reg <= s14_next;
            s15_reg <= s15_next;
            v16_reg <= v16_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d11_reg  <= d11_next;
            r11_reg  <= r11_next;
            ex11_reg <= ex11_next;
            t12_reg  <= t12_next;
            r12_reg  <= r12_next;
            ex12_reg <= ex12_next;
            r13_reg  <= r13_next;
            ex13_reg <= ex13_next;
            q14_reg  <= q14_next;
            q15_reg  <= q15_next;
            q16_reg  <= q16_next;
            l16_reg  <= l16_next;
        end
    end

    assign out_valid   = v16_reg;
    assign result_bits = q16_reg;
    assign last_out    = l16_reg;

endmodule

// ===== verif/fsga_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsga_checker
// Watches the input, output and register-write ports of the gated sigmoid
// activation, predicts each result in fp16 arithmetic and compares it in order.
// ----------------------------------------------------------------------------
module fsga_checker
    import fsga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // x_value[15:0], y_value[31:16], up_value[47:32]
    input  logic        s_axis_tlast,   // last_in
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // result_bits[15:0]
    input  logic        m_axis_tlast,   // last_out
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] bits;
        logic        last;
    } activation_t;

    activation_t expected_results[$];

    logic [15:0] beta_reg;
    logic [15:0] offset_reg;
    logic        use_y_reg;
    logic        use_up_reg;

    function automatic logic is_nan16(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic logic is_inf16(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    endfunction

    // finite values only
    function automatic real half_to_real(input logic [15:0] h);
        real v;
        int  k;
        v = (h[14:10] == 5'd0) ? real'(h[9:0]) : real'({1'b1, h[9:0]});
        k = (h[14:10] == 5'd0) ? -24 : int'(h[14:10]) - 25;
        while (k > 0)
        begin
            v = v * 2.0;
            k--;
        end
        while (k < 0)
        begin
            v = v * 0.5;
            k++;
        end
        return h[15] ? -v : v;
    endfunction

    // round v + err to fp16, nearest even; err lies far below one fp16 ulp
    function automatic logic [15:0] round_to_half(input real v, input real err,
                                                  input logic zsign);
        logic sg;
        logic up;
        real  a, p, m, fr, tw;
        int   e, mi;
        if (v == 0.0)
            return {zsign, 15'd0};
        sg = (v < 0.0);
        a  = sg ? -v : v;
        if (a >= 65536.0)
            return {sg, 15'h7C00};
        p = 32768.0;
        e = 15;
        while (a < p && e > -14)
        begin
            p = p / 2.0;
            e--;
        end
        m  = a / (p / 1024.0);
        mi = $rtoi(m);
        fr = m - real'(mi);
        if (fr > 0.5)
            up = 1'b1;
        else if (fr < 0.5)
            up = 1'b0;
        else
        begin
            tw = sg ? -err : err;
            if (tw > 0.0)
                up = 1'b1;
            else if (tw < 0.0)
                up = 1'b0;
            else
                up = mi[0];
        end
        if (up)
            mi++;
        if (a >= p)
            return {sg, 15'((e + 15) * 1024 + mi - 1024)};
        return {sg, 15'(mi)};
    endfunction

    // a*b + c, single rounding; a product is a*b + -0, a sum is a*1 + c
    function automatic logic [15:0] half_fma(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] c);
        logic ps, p_inf, p_nan;
        real  p, dc, s, err, bb;
        ps    = a[15] ^ b[15];
        p_inf = is_inf16(a) | is_inf16(b);
        p_nan = is_nan16(a) | is_nan16(b) | (is_inf16(a) && b[14:0] == 15'd0)
              | (is_inf16(b) && a[14:0] == 15'd0);
        if (p_nan || is_nan16(c) || (p_inf && is_inf16(c) && ps != c[15]))
            return H_NAN;
        if (p_inf)
            return {ps, 15'h7C00};
        if (is_inf16(c))
            return {c[15], 15'h7C00};
        p   = half_to_real(a) * half_to_real(b);
        dc  = half_to_real(c);
        s   = p + dc;
        bb  = s - p;
        err = (p - (s - bb)) + (dc - bb);
        return round_to_half(s, err, ps & c[15]);
    endfunction

    function automatic logic [15:0] half_mul(input logic [15:0] a, input logic [15:0] b);
        return half_fma(a, b, H_NZERO);
    endfunction

    function automatic logic [15:0] half_add(input logic [15:0] a, input logic [15:0] b);
        return half_fma(a, H_ONE, b);
    endfunction

    function automatic int half_to_int8(input logic [15:0] h);
        real v, fr;
        int  t;
        if (is_nan16(h))
            return 127;
        if (is_inf16(h))
            return h[15] ? -128 : 127;
        v = half_to_real(h);
        if (v >= 127.0)
            return 127;
        if (v <= -128.0)
            return -128;
        t = $rtoi(v);
        if (real'(t) > v)
            t--;
        fr = v - real'(t);
        if (fr > 0.5 || (fr == 0.5 && t[0]))
            t++;
        return t;
    endfunction

    function automatic logic [15:0] recip_estimate(input logic [15:0] h);
        logic [10:0] sig;
        logic [9:0]  osig;
        int          ne, oe;
        sig = {1'b0, h[9:0]};
        if (h[14:10] == 5'h1F)
            return (h[9:0] != 10'd0) ? H_NAN : {h[15], 15'd0};
        if (h[14:0] == 15'd0)
            return {h[15], 15'h7C00};
        if (h[14:10] == 5'd0)
        begin
            ne = 1;
            while (!sig[10])
            begin
                sig = sig << 1;
                ne--;
            end
        end
        else
            ne = int'(h[14:10]);
        if (ne < -1)
            return {h[15], 15'h7C00};
        osig = {REC7_TAB[sig[9:3]], 3'b000};
        oe   = 29 - ne;
        if (oe >= 1)
            return {h[15], 5'(oe), osig};
        return {h[15], 15'({1'b1, osig} >> (1 - oe))};
    endfunction

    function automatic logic [15:0] predict_activation(input logic [15:0] x,
                                                       input logic [15:0] y,
                                                       input logic [15:0] upv);
        logic [15:0] vx, v, z, s, u, e, ex, d, r, t, q;
        logic [7:0]  step8;
        logic        neg;
        int          zi;
        vx = (beta_reg != H_ONE) ? half_mul(x, beta_reg) : x;
        neg = vx[15] && vx[14:0] != 15'd0 && !is_nan16(vx);
        vx = {1'b1, vx[14:0]};
        // clamp keeps the number over a NaN
        if (is_nan16(vx) || is_inf16(vx) || half_to_real(vx) <= half_to_real(H_CLAMP))
            vx = H_CLAMP;

        v  = half_mul(vx, H_INV_LN2);
        zi = half_to_int8(v);
        z  = round_to_half(real'(zi), 0.0, 1'b0);
        s  = half_fma(H_LN2_HI ^ H_SIGN, z, vx);
        s  = half_fma(H_LN2_LO ^ H_SIGN, z, s);

        u = half_fma(H_P3, s, H_P2);
        u = half_fma(s, u, H_ONE);
        u = half_fma(s, u, H_ONE);

        // exponent insertion wraps in 8 bits, then in 16
        step8 = 8'(88 + zi * 8);
        e  = u + 16'($signed(step8) * 128);
        ex = half_mul(e, H_DOWN11);

        d = half_add(ex, H_ONE);
        r = recip_estimate(d);
        t = half_fma(d ^ H_SIGN, r, H_ONE);
        r = half_fma(t, r, r);

        q = neg ? half_mul(r, ex) : r;
        if (use_y_reg)
            q = half_mul(q, y);
        if (use_up_reg)
            q = half_mul(q, half_add(upv, offset_reg));
        return q;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        activation_t exp_item;
        if (!rst_n)
        begin
            beta_reg   <= H_ONE;
            offset_reg <= 16'd0;
            use_y_reg  <= 1'b0;
            use_up_reg <= 1'b0;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BETA_SCALE: beta_reg   <= cfg_wdata;
                    CFG_UP_OFFSET:  offset_reg <= cfg_wdata;
                    CFG_USE_Y:      use_y_reg  <= cfg_wdata[0];
                    CFG_USE_UP:     use_up_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back({predict_activation(s_axis_tdata[15:0],
                    s_axis_tdata[31:16], s_axis_tdata[47:32]), s_axis_tlast});
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_item = expected_results.pop_front();
                    if (exp_item.bits !== m_axis_tdata || exp_item.last !== m_axis_tlast)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h last %b, got %h last %b",
                                     exp_item.bits, exp_item.last, m_axis_tdata,
                                     m_axis_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the gated sigmoid activation: directed special values, then
// random phases under several register settings with bursty input, a
// stalling receiver and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import fsga_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 240;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          burst_left;
    logic        hold_request;

    fp16_sigmoid_gated_activation i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    fsga_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("fp16_sigmoid_gated_activation verification failed");
                $finish;
            end
        end
    end

    // receiver: stall mode is redrawn at random periodically; one long hold on request
    initial
    begin
        int mode;
        int hold_left;
        mode = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (cycle_count % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_request && hold_left == 0)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 4) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // one transaction; gaps fall between bursts of random length
    task automatic send_element(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] upv, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {upv, y, x};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] beta, input logic [15:0] offset,
                                input logic uy, input logic uu);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BETA_SCALE;
        cfg_wdata <= beta;
        @(posedge clk);
        cfg_index <= CFG_UP_OFFSET;
        cfg_wdata <= offset;
        @(posedge clk);
        cfg_index <= CFG_USE_Y;
        cfg_wdata <= {15'd0, uy};
        @(posedge clk);
        cfg_index <= CFG_USE_UP;
        cfg_wdata <= {15'd0, uu};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly moderate magnitudes, a quarter fully random patterns
    function automatic logic [15:0] random_half;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(9, 20)), 10'($urandom)};
    endfunction

    logic [15:0] special_x [0:21] = '{
        16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'hFFFF, 16'h3C00,
        16'hBC00, 16'h7BFF, 16'hFBFF, 16'h0001, 16'h8001, 16'h4900, 16'hC900, 16'hCC56,
        16'hCC57, 16'h5640, 16'hD640, 16'h0400, 16'h3800, 16'hB800
    };

    logic [15:0] phase_beta   [0:7];
    logic [15:0] phase_offset [0:7];
    logic        phase_use_y  [0:7];
    logic        phase_use_up [0:7];

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 48'd0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BETA_SCALE;
        cfg_wdata     = 16'd0;
        burst_left    = 0;
        hold_request  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain sigmoid on special values
        for (int i = 0; i < 22; i++)
            send_element(special_x[i], 16'($urandom), 16'($urandom), i[0]);
        drain();

        phase_beta   = '{H_ONE, 16'h0000, 16'hFFFF, 16'h7BFF, 16'h0001, 16'hC000,
                         16'h7C00, 16'h3E00};
        phase_offset = '{16'h0000, 16'hFFFF, 16'h0000, 16'h7C00, 16'h8000, 16'h3C00,
                         16'h7BFF, 16'hBC00};
        phase_use_y  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_use_up = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 5)
                write_config(random_half(), random_half(), 1'b1, 1'b1);
            else
                write_config(phase_beta[ph], phase_offset[ph], phase_use_y[ph],
                             phase_use_up[ph]);
            if (ph == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_element(random_half(), random_half(), random_half(),
                             $urandom_range(0, 7) == 0);
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("fp16_sigmoid_gated_activation verification clean");
        else
            $display("fp16_sigmoid_gated_activation verification failed");
        $finish;
    end

endmodule
